>>> design/tks_pkg.sv
// Shared types and constants for the top-k refinement selector.
package tks_pkg;

  localparam int SLOTS      = 16;
  localparam int POINT_BITS = 20;
  localparam int DIM_BITS   = 6;
  localparam int ERR_BITS   = 32;
  localparam int SLOT_BITS  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_BITS   = $clog2(SLOTS + 1);
  localparam int ENTRY_BITS = ERR_BITS + POINT_BITS + DIM_BITS;
  localparam int IN_TDATA_BITS  = ((ENTRY_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_BITS = ((ENTRY_BITS + 7) / 8) * 8;
  localparam int APB_ADDR_BITS  = 3;

  localparam logic FUNC_OFFER = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  // Register index, taken from paddr[2].
  localparam logic REG_FLOOR     = 1'b0;
  localparam logic REG_THRESHOLD = 1'b1;

  typedef struct packed {
    logic signed [ERR_BITS-1:0] error;
    logic [POINT_BITS-1:0]      point;
    logic [DIM_BITS-1:0]        dim;
  } slot_entry_t;

  typedef struct packed {
    logic                 we;
    logic [SLOT_BITS-1:0] waddr;
    slot_entry_t          wdata;
    logic                 re;
    logic [SLOT_BITS-1:0] raddr;
  } ram_req_t;

endpackage

>>> design/top_k_refinement_selector.sv
// Top level of the top-k refinement selector: ports, packing and instances.
//
//  channel   dir   handshake          payload
//  s_*       in    tvalid/tready      tdata: point, dimension, error; tuser: func
//  m_*       out   tvalid/tready      tdata: point, dimension, error; tuser: refine;
//                                     tlast: last slot
//  APB       in    psel/penable       reg 0 floor_value, reg 1 refine_threshold
//
// An offer that loses returns to idle after the compare; one that wins goes on
// to a rescan that reads every slot once through the single memory read port.
// A drain gives one item per cycle, refilling each slot as it goes; a stalled
// m_tready holds the sweep.
// Reset (synchronous, high) clears the state and config registers, the slot valid
// bits and the minimum pointer; no clearing pass is needed.
module top_k_refinement_selector (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [tks_pkg::IN_TDATA_BITS-1:0]      s_tdata,  // point, dimension, error
  input  logic                                   s_tuser,  // func
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [tks_pkg::OUT_TDATA_BITS-1:0]     m_tdata,  // point, dimension, error
  output logic                                   m_tuser,  // refine_flag
  output logic                                   m_tlast,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [tks_pkg::APB_ADDR_BITS-1:0]      paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);
  import tks_pkg::*;

  logic signed [ERR_BITS-1:0] floor_value;
  logic signed [ERR_BITS-1:0] refine_threshold;
  ram_req_t                   ram_req;
  slot_entry_t                ram_rdata;
  logic [POINT_BITS-1:0]      out_point;
  logic [DIM_BITS-1:0]        out_dim;
  logic signed [ERR_BITS-1:0] out_error;

  tks_cfg_regs u_cfg (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .floor_value      (floor_value),
    .refine_threshold (refine_threshold)
  );

  tks_slot_ram u_ram (
    .clk   (clk),
    .rst   (rst),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  tks_engine u_engine (
    .clk              (clk),
    .rst              (rst),
    .s_tvalid         (s_tvalid),
    .s_tready         (s_tready),
    .in_func          (s_tuser),
    .in_point         (s_tdata[POINT_BITS-1:0]),
    .in_dim           (s_tdata[POINT_BITS +: DIM_BITS]),
    .in_error         (s_tdata[POINT_BITS+DIM_BITS +: ERR_BITS]),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .out_point        (out_point),
    .out_dim          (out_dim),
    .out_error        (out_error),
    .out_refine       (m_tuser),
    .out_last         (m_tlast),
    .floor_value      (floor_value),
    .refine_threshold (refine_threshold),
    .ram_req          (ram_req),
    .ram_rdata        (ram_rdata)
  );

  assign m_tdata = OUT_TDATA_BITS'({out_error, out_dim, out_point});

endmodule

>>> design/tks_cfg_regs.sv
// APB register file holding the floor and the refine threshold.
module tks_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tks_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  output logic signed [tks_pkg::ERR_BITS-1:0] floor_value,
  output logic signed [tks_pkg::ERR_BITS-1:0] refine_threshold
);
  import tks_pkg::*;

  logic wr_go;

  assign pready = 1'b1;
  assign wr_go  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      floor_value      <= '0;
      refine_threshold <= '0;
    end else if (wr_go) begin
      unique case (paddr[2])
        REG_FLOOR:     floor_value      <= pwdata;
        REG_THRESHOLD: refine_threshold <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FLOOR:     prdata = floor_value;
      REG_THRESHOLD: prdata = refine_threshold;
      default:       prdata = '0;
    endcase
  end

endmodule

>>> design/tks_slot_ram.sv
// Slot memory, one write and one registered read port; unwritten slots read as zero.
module tks_slot_ram (
  input  logic                  clk,
  input  logic                  rst,
  input  tks_pkg::ram_req_t     req,
  output tks_pkg::slot_entry_t  rdata
);
  import tks_pkg::*;

  slot_entry_t       mem [SLOTS];
  logic [SLOTS-1:0]  written;
  slot_entry_t       rd_q;
  logic              rd_written;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_q <= mem[req.raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (req.we) begin
        written[req.waddr] <= 1'b1;
      end
      if (req.re) begin
        rd_written <= written[req.raddr];
      end
    end
  end

  assign rdata = rd_written ? rd_q : '0;

endmodule

>>> design/tks_engine.sv
// Sequencer: offer compare and rescan, drain with refill, output register.
module tks_engine (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic                                  in_func,
  input  logic [tks_pkg::POINT_BITS-1:0]        in_point,
  input  logic [tks_pkg::DIM_BITS-1:0]          in_dim,
  input  logic signed [tks_pkg::ERR_BITS-1:0]   in_error,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [tks_pkg::POINT_BITS-1:0]        out_point,
  output logic [tks_pkg::DIM_BITS-1:0]          out_dim,
  output logic signed [tks_pkg::ERR_BITS-1:0]   out_error,
  output logic                                  out_refine,
  output logic                                  out_last,
  input  logic signed [tks_pkg::ERR_BITS-1:0]   floor_value,
  input  logic signed [tks_pkg::ERR_BITS-1:0]   refine_threshold,
  output tks_pkg::ram_req_t                     ram_req,
  input  tks_pkg::slot_entry_t                  ram_rdata
);
  import tks_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_OFFER_CMP,
    ST_SCAN,
    ST_DRAIN_OUT
  } state_t;

  localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(SLOTS - 1);

  state_t                     state;
  logic [SLOT_BITS-1:0]       min_slot;
  logic [SLOT_BITS-1:0]       idx;
  logic [CNT_BITS-1:0]        ri;
  logic                       cmp_vld;
  logic [SLOT_BITS-1:0]       cmp_idx;
  logic signed [ERR_BITS-1:0] best_err;
  logic [SLOT_BITS-1:0]       best_idx;
  slot_entry_t                hold;

  logic out_free;
  logic emit;
  logic offer_wins;
  logic take_new;
  logic refine;

  assign s_tready   = (state == ST_IDLE);
  assign out_free   = !m_tvalid || m_tready;
  assign emit       = (state == ST_DRAIN_OUT) && out_free;
  assign offer_wins = hold.error > ram_rdata.error;
  assign take_new   = (cmp_idx == '0) || (ram_rdata.error < best_err);
  assign refine     = (ram_rdata.error > floor_value) &&
                      (ram_rdata.error >= refine_threshold);

  always_comb begin
    ram_req = '0;
    unique case (state)
      ST_IDLE: begin
        ram_req.re    = s_tvalid;
        ram_req.raddr = (in_func == FUNC_DRAIN) ? '0 : min_slot;
      end
      ST_OFFER_CMP: begin
        ram_req.we    = offer_wins;
        ram_req.waddr = min_slot;
        ram_req.wdata = hold;
      end
      ST_SCAN: begin
        ram_req.re    = (ri < CNT_BITS'(SLOTS));
        ram_req.raddr = ri[SLOT_BITS-1:0];
      end
      ST_DRAIN_OUT: begin
        // refill the slot just shown, prefetch the next one
        ram_req.we          = out_free;
        ram_req.waddr       = idx;
        ram_req.wdata.error = floor_value;
        ram_req.re          = out_free && (idx != LAST_SLOT);
        ram_req.raddr       = SLOT_BITS'(idx + 1'b1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      min_slot <= '0;
      idx      <= '0;
      ri       <= '0;
      cmp_vld  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            hold.error <= in_error;
            hold.point <= in_point;
            hold.dim   <= in_dim;
            idx        <= '0;
            state      <= (in_func == FUNC_DRAIN) ? ST_DRAIN_OUT : ST_OFFER_CMP;
          end
        end
        ST_OFFER_CMP: begin
          ri      <= '0;
          cmp_vld <= 1'b0;
          state   <= offer_wins ? ST_SCAN : ST_IDLE;
        end
        ST_SCAN: begin
          // read port is idle once the last slot has been requested
          cmp_vld <= ram_req.re;
          cmp_idx <= ri[SLOT_BITS-1:0];
          if (ram_req.re) begin
            ri <= CNT_BITS'(ri + 1'b1);
          end
          if (cmp_vld && take_new) begin
            best_err <= ram_rdata.error;
            best_idx <= cmp_idx;
          end
          if (cmp_vld && (cmp_idx == LAST_SLOT)) begin
            min_slot <= take_new ? cmp_idx : best_idx;
            state    <= ST_IDLE;
          end
        end
        ST_DRAIN_OUT: begin
          if (out_free) begin
            out_point  <= ram_rdata.point;
            out_dim    <= ram_rdata.dim;
            out_error  <= ram_rdata.error;
            out_refine <= refine;
            out_last   <= (idx == LAST_SLOT);
            if (idx == LAST_SLOT) begin
              min_slot <= '0;
              state    <= ST_IDLE;
            end else begin
              idx <= SLOT_BITS'(idx + 1'b1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    ram_req.we |-> (state == ST_OFFER_CMP) || (state == ST_DRAIN_OUT))
    else $error("slot write outside compare or drain");

  a_drain_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN_OUT) && out_free && (idx == LAST_SLOT)
      |=> (state == ST_IDLE) && (min_slot == '0) && m_tvalid && out_last)
    else $error("drain did not close on the last slot");

  a_scan_no_output: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |=> !$rose(m_tvalid))
    else $error("item emitted during rescan");

  a_offer_read_slot: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) && s_tvalid && (in_func == FUNC_OFFER)
      |-> ram_req.re && (ram_req.raddr == min_slot))
    else $error("offer did not read the minimum slot");

endmodule
